// File: sv/mda_tcr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MDA text cell renderer.
// No dependencies; imported by every module of the block.
package mda_tcr_pkg;

   // Field widths
   localparam int CodeW    = 8;
   localparam int AttrW    = 8;
   localparam int GlyphW   = 8;
   localparam int PixW     = 2;
   localparam int PixelsW  = 18;
   localparam int FrameW   = 5;
   localparam int ModeW    = 8;
   localparam int CsrDataW = 32;
   localparam int CsrAddrW = 2;

   // Item kinds
   localparam logic OP_CELL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register map
   localparam logic [CsrAddrW-1:0] ADDR_MODE_CONTROL = 2'd0;

   // Mode decode
   localparam logic [ModeW-1:0] MODE_MASK  = 8'h2a;
   localparam logic [ModeW-1:0] MODE_INTEN = 8'h08;
   localparam logic [ModeW-1:0] MODE_BLINK = 8'h28;

   // Attribute codes and masks
   localparam logic [AttrW-1:0] ATTR_REV       = 8'h70;
   localparam logic [AttrW-1:0] ATTR_REV_HI    = 8'h78;
   localparam logic [AttrW-1:0] ATTR_REV_BL    = 8'hF0;
   localparam logic [AttrW-1:0] ATTR_REV_BL_HI = 8'hF8;
   localparam logic [AttrW-1:0] ATTR_VIS_MASK  = 8'h77;
   localparam logic [AttrW-1:0] ATTR_UL_MASK   = 8'h07;
   localparam logic [AttrW-1:0] ATTR_UL        = 8'h01;

   // Box-drawing range for the ninth column
   localparam logic [CodeW-1:0] CODE_BOX_MASK = 8'hE0;
   localparam logic [CodeW-1:0] CODE_BOX      = 8'hC0;

   // Palette indices
   localparam logic [PixW-1:0] PAL_BLACK  = 2'd0;
   localparam logic [PixW-1:0] PAL_DIM    = 2'd1;
   localparam logic [PixW-1:0] PAL_NORMAL = 2'd2;
   localparam logic [PixW-1:0] PAL_BRIGHT = 2'd3;

   // Per-cell render controls from the top level to the shading logic
   typedef struct packed {
      logic blink_mode;   // blink text mode selected
      logic cursor_phase; // frame counter bit 3
      logic blink_phase;  // frame counter bit 4
   } render_ctl_type;

endpackage

// File: sv/mda_tcr_csr.sv
`timescale 1ns / 1ps
// APB-style register block holding the mode control byte.
// Depends on mda_tcr_pkg.
module mda_tcr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mda_tcr_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [mda_tcr_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [mda_tcr_pkg::CsrDataW-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic                             text_on,
   output logic                             blink_mode
);
   import mda_tcr_pkg::*;

   logic [ModeW-1:0] mode_ff;
   logic [ModeW-1:0] mode_in;
   logic [ModeW-1:0] mode_sel;
   logic             wr_en;

   // Take a write on the access phase
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr == ADDR_MODE_CONTROL);

   always_comb begin
      mode_in = mode_ff;
      if (wr_en) begin
         mode_in = csr_pwdata[ModeW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Read back the register; other addresses read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_MODE_CONTROL) begin
         csr_prdata = {{(CsrDataW-ModeW){1'b0}}, mode_ff};
      end
   end

   assign csr_pready = 1'b1;

   // Decode the text mode
   assign mode_sel   = mode_ff & MODE_MASK;
   assign blink_mode = (mode_sel == MODE_BLINK);
   assign text_on    = (mode_sel == MODE_BLINK) || (mode_sel == MODE_INTEN);

endmodule

// File: sv/mda_tcr_shade.sv
`timescale 1ns / 1ps
// Combinational cell shading: attribute rules, cursor, blink and pixel expansion.
// Depends on mda_tcr_pkg.
module mda_tcr_shade (
   input  logic [mda_tcr_pkg::CodeW-1:0]   char_code,
   input  logic [mda_tcr_pkg::AttrW-1:0]   attribute,
   input  logic [mda_tcr_pkg::GlyphW-1:0]  glyph_bits,
   input  logic                            is_cursor,
   input  mda_tcr_pkg::render_ctl_type     ctl,
   output logic [mda_tcr_pkg::PixelsW-1:0] pixels
);
   import mda_tcr_pkg::*;

   logic [PixW-1:0]   fg;
   logic [PixW-1:0]   bg;
   logic [GlyphW-1:0] data;

   // Pick colours from the attribute
   always_comb begin
      fg = attribute[3] ? PAL_BRIGHT : PAL_NORMAL;
      bg = PAL_BLACK;
      unique case (attribute)
         ATTR_REV: begin
            bg = PAL_NORMAL;
            fg = PAL_BLACK;
         end
         ATTR_REV_HI: begin
            bg = PAL_NORMAL;
            fg = PAL_DIM;
         end
         ATTR_REV_BL: begin
            bg = ctl.blink_mode ? PAL_NORMAL : PAL_BRIGHT;
            fg = PAL_BLACK;
         end
         ATTR_REV_BL_HI: begin
            bg = ctl.blink_mode ? PAL_NORMAL : PAL_BRIGHT;
            fg = PAL_DIM;
         end
         default: begin
         end
      endcase
   end

   // Apply invisible, underline, cursor and blink to the scanline byte
   always_comb begin
      data = glyph_bits;
      if ((attribute & ATTR_VIS_MASK) == '0) begin
         data = '0;
      end
      if ((attribute & ATTR_UL_MASK) == ATTR_UL) begin
         data = '1;
      end
      if (is_cursor) begin
         if (ctl.cursor_phase) begin
            data = '1;
         end
      end else if (ctl.blink_mode && attribute[7] && ctl.blink_phase) begin
         data = '0;
      end
   end

   // Expand to nine pixels, leftmost in the top bits
   always_comb begin
      for (int k = 0; k < GlyphW; k++) begin
         pixels[PixelsW-1-PixW*k -: PixW] = data[GlyphW-1-k] ? fg : bg;
      end
      if ((char_code & CODE_BOX_MASK) == CODE_BOX) begin
         pixels[PixW-1:0] = data[0] ? fg : bg;
      end else begin
         pixels[PixW-1:0] = bg;
      end
   end

endmodule

// File: sv/mda_text_cell_renderer_core.sv
`timescale 1ns / 1ps
// Top level of the MDA text cell renderer: input stage, frame counter, result stage.
// Depends on mda_tcr_pkg, mda_tcr_csr and mda_tcr_shade.
//
//  channel | ports                          | moves
//  --------+--------------------------------+--------------------------------
//  req     | req_valid/req_ready + fields   | one cell or vsync tick request
//  rsp     | rsp_valid/rsp_ready, pixels    | nine 2-bit pixels per shown cell
//  csr     | csr_psel/penable/pwrite/paddr  | mode control byte at address 0
//
// One request per cycle while results are not stalled. A cell passes the input register,
// then the result register, and rsp_valid rises once the result register holds it. Ticks
// and cells in display-off mode leave the input register without a result. A stalled
// result holds a cell in the input register and drops req_ready; ticks and display-off
// cells still pass. Synchronous reset clears the valid flags, the frame counter and the
// mode byte (display off).
module mda_text_cell_renderer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [mda_tcr_pkg::CodeW-1:0]    req_char_code,
   input  logic [mda_tcr_pkg::AttrW-1:0]    req_attribute,
   input  logic [mda_tcr_pkg::GlyphW-1:0]   req_glyph_bits,
   input  logic                             req_is_cursor,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mda_tcr_pkg::PixelsW-1:0]  rsp_pixels,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mda_tcr_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [mda_tcr_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [mda_tcr_pkg::CsrDataW-1:0] csr_prdata,
   output logic                             csr_pready
);
   import mda_tcr_pkg::*;

   logic               text_on;
   logic               blink_mode;

   logic               in_valid_ff, in_valid_in;
   logic               in_op_ff;
   logic [CodeW-1:0]   in_code_ff;
   logic [AttrW-1:0]   in_attr_ff;
   logic [GlyphW-1:0]  in_glyph_ff;
   logic               in_cursor_ff;

   logic [FrameW-1:0]  frame_ff, frame_in;
   logic               out_valid_ff, out_valid_in;
   logic [PixelsW-1:0] out_pixels_ff;
   logic [PixelsW-1:0] shade_pixels;

   logic               out_space;
   logic               makes_rsp;
   logic               in_advance;
   logic               req_take;
   render_ctl_type     ctl;

   mda_tcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .text_on     (text_on),
      .blink_mode  (blink_mode)
   );

   // Render controls from the current frame count: blink mode, cursor phase, blink phase
   assign ctl = {blink_mode, frame_ff[3], frame_ff[4]};

   mda_tcr_shade u_shade (
      .char_code  (in_code_ff),
      .attribute  (in_attr_ff),
      .glyph_bits (in_glyph_ff),
      .is_cursor  (in_cursor_ff),
      .ctl        (ctl),
      .pixels     (shade_pixels)
   );

   // Advance the input register when its request can move on
   assign out_space  = !out_valid_ff || rsp_ready;
   assign makes_rsp  = (in_op_ff == OP_CELL) && text_on;
   assign in_advance = in_valid_ff && (!makes_rsp || out_space);
   assign req_ready  = !in_valid_ff || in_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   // Count ticks as they leave the input register
   always_comb begin
      frame_in = frame_ff;
      if (in_advance && (in_op_ff == OP_TICK)) begin
         frame_in = frame_ff + 1'b1;
      end
   end

   // Load or drain the result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (in_advance && makes_rsp) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         frame_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         frame_ff     <= frame_in;
      end
   end

   // Hold payloads; no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff     <= req_op;
         in_code_ff   <= req_char_code;
         in_attr_ff   <= req_attribute;
         in_glyph_ff  <= req_glyph_bits;
         in_cursor_ff <= req_is_cursor;
      end
      if (in_advance && makes_rsp) begin
         out_pixels_ff <= shade_pixels;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_pixels = out_pixels_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mda_text_cell_renderer_core: pixel prediction and checking.
// Depends on mda_tcr_pkg and the block's RTL; needs no files or arguments.
module tb_top;
   import mda_tcr_pkg::*;

   localparam int GapMax         = 17;
   localparam int SettleCycles   = 4;
   localparam int EndCycles      = 8;
   localparam int WatchdogLimit  = 1000;
   localparam int ReportLimit    = 10;
   localparam int FirstUnmapped  = ADDR_MODE_CONTROL + 1;
   localparam int AddrCount      = 1 << CsrAddrW;
   localparam logic [ModeW-1:0] MODE_OFF      = 8'h00;
   localparam logic [ModeW-1:0] MODE_ALL_ONES = 8'hFF;
   localparam logic [ModeW-1:0] MODE_SPARE    = ~MODE_MASK;

   typedef struct {
      logic              op;
      logic [CodeW-1:0]  code;
      logic [AttrW-1:0]  attr;
      logic [GlyphW-1:0] glyph;
      logic              cursor;
   } cell_req_type;

   // Shading predictor with its own copy of the mode byte and frame counter
   class cell_render_check_type;
      logic [ModeW-1:0]   mode_byte;
      logic [FrameW-1:0]  frames;
      logic [PixelsW-1:0] pending_pixels[$];
      int                 mismatches;

      function void flag(string what, logic [CsrDataW-1:0] want, logic [CsrDataW-1:0] got);
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("%0t: %s: expected %05h got %05h", $realtime, what, want, got);
      endfunction

      function logic [PixelsW-1:0] shade_cell(cell_req_type r);
         logic              blinking;
         logic [PixW-1:0]   fg;
         logic [PixW-1:0]   bg;
         logic [GlyphW-1:0] data;
         logic [PixelsW-1:0] pix;
         blinking = (mode_byte & MODE_MASK) == MODE_BLINK;
         fg = r.attr[3] ? PAL_BRIGHT : PAL_NORMAL;
         bg = PAL_BLACK;
         data = r.glyph;
         if ((r.attr & ATTR_VIS_MASK) == '0)
            data = '0;
         // reverse video; the intense background only outside blink mode
         case (r.attr)
            ATTR_REV: begin
               bg = PAL_NORMAL;
               fg = PAL_BLACK;
            end
            ATTR_REV_HI: begin
               bg = PAL_NORMAL;
               fg = PAL_DIM;
            end
            ATTR_REV_BL: begin
               bg = blinking ? PAL_NORMAL : PAL_BRIGHT;
               fg = PAL_BLACK;
            end
            ATTR_REV_BL_HI: begin
               bg = blinking ? PAL_NORMAL : PAL_BRIGHT;
               fg = PAL_DIM;
            end
            default: ;
         endcase
         if ((r.attr & ATTR_UL_MASK) == ATTR_UL)
            data = '1;
         // cursor overrides attribute blink on its own cell
         if (r.cursor) begin
            if (frames[3])
               data = '1;
         end else if (blinking && r.attr[7] && frames[4]) begin
            data = '0;
         end
         for (int k = 0; k < 8; k++)
            pix[PixelsW-1-2*k -: PixW] = data[7-k] ? fg : bg;
         if ((r.code & CODE_BOX_MASK) == CODE_BOX)
            pix[PixW-1:0] = data[0] ? fg : bg;
         else
            pix[PixW-1:0] = bg;
         return pix;
      endfunction

      function void note_request(cell_req_type r);
         logic [ModeW-1:0] sel;
         sel = mode_byte & MODE_MASK;
         if (r.op == OP_TICK)
            frames = frames + 1'b1;
         else if (sel == MODE_INTEN || sel == MODE_BLINK)
            pending_pixels.push_back(shade_cell(r));
      endfunction

      function void check_pixels(logic [PixelsW-1:0] got);
         logic [PixelsW-1:0] want;
         if (pending_pixels.size() == 0) begin
            flag("unexpected pixels", '0, CsrDataW'(got));
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want)
               flag("pixels mismatch", CsrDataW'(want), CsrDataW'(got));
         end
      endfunction

      function void close();
         if (pending_pixels.size() != 0)
            flag("results never delivered", pending_pixels.size(), 0);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid;
   logic req_ready;
   logic req_op;
   logic [CodeW-1:0]    req_char_code;
   logic [AttrW-1:0]    req_attribute;
   logic [GlyphW-1:0]   req_glyph_bits;
   logic                req_is_cursor;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PixelsW-1:0]  rsp_pixels;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   cell_render_check_type book = new;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   int idle_count = 0;

   mda_text_cell_renderer_core uut (.*);

   always #1 clock = ~clock;

   function automatic int idle_draw(bit steady);
      return steady ? 0 : $urandom_range(0, GapMax);
   endfunction

   // Drive one request; entered and left at a falling edge
   task automatic send_request(cell_req_type r);
      int gap;
      if ($urandom_range(0, 39) == 0)
         tx_steady = !tx_steady;
      gap = idle_draw(tx_steady);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op         = r.op;
      req_char_code  = r.code;
      req_attribute  = r.attr;
      req_glyph_bits = r.glyph;
      req_is_cursor  = r.cursor;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      book.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_cell(logic [CodeW-1:0] code, logic [AttrW-1:0] attr,
                            logic [GlyphW-1:0] glyph, logic cursor);
      send_request('{OP_CELL, code, attr, glyph, cursor});
   endtask

   task automatic send_ticks(int n);
      repeat (n)
         send_request('{OP_TICK, CodeW'($urandom), AttrW'($urandom), GlyphW'($urandom),
                        1'($urandom)});
   endtask

   task automatic stop_requests();
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (book.pending_pixels.size() != 0)
         @(negedge clock);
   endtask

   // Setup then access; read back when the register is mapped
   task automatic csr_write(logic [CsrAddrW-1:0] addr, logic [ModeW-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = {(CsrDataW-ModeW)'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_MODE_CONTROL)
         book.mode_byte = value;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (addr == ADDR_MODE_CONTROL) begin
         @(negedge clock);
         csr_penable = 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== CsrDataW'(value))
            book.flag("mode readback", CsrDataW'(value), csr_prdata);
         @(negedge clock);
         csr_penable = 1'b0;
      end
      csr_psel = 1'b0;
   endtask

   // Hold off until the block is idle, then change the mode
   task automatic set_mode(logic [ModeW-1:0] value);
      stop_requests();
      wait_drained();
      repeat (SettleCycles) @(negedge clock);
      csr_write(ADDR_MODE_CONTROL, value);
   endtask

   function automatic cell_req_type random_cell();
      cell_req_type r;
      logic [AttrW-1:0] rev_codes[4];
      logic [AttrW-1:0] noise;
      rev_codes = '{ATTR_REV, ATTR_REV_HI, ATTR_REV_BL, ATTR_REV_BL_HI};
      noise = AttrW'($urandom);
      r.op = OP_CELL;
      r.code = ($urandom_range(0, 2) == 0) ? (CODE_BOX | (noise & ~CODE_BOX_MASK))
                                            : CodeW'($urandom);
      case ($urandom_range(0, 5))
         2: r.attr = rev_codes[$urandom_range(0, 3)];
         3: r.attr = (noise & ~ATTR_UL_MASK) | ATTR_UL;
         4: r.attr = noise & ~ATTR_VIS_MASK;
         5: r.attr = noise | 8'h80;
         default: r.attr = AttrW'($urandom);
      endcase
      r.glyph = GlyphW'($urandom);
      r.cursor = ($urandom_range(0, 3) == 0);
      return r;
   endfunction

   // Random cells with bursts of ticks to sweep the frame counter
   task automatic run_phase(logic [ModeW-1:0] value, int n, bit hold_off);
      int count;
      int burst;
      set_mode(value);
      count = 0;
      while (count < n) begin
         if (hold_off && count >= n / 2) begin
            stop_requests();
            wait_drained();
            hold_off = 1'b0;
         end
         if ($urandom_range(0, 6) == 0) begin
            burst = $urandom_range(1, 8);
            send_ticks(burst);
            count += burst;
         end else begin
            send_request(random_cell());
            count++;
         end
      end
   endtask

   // Result side: random stalls, check each accepted result
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if ($urandom_range(0, 29) == 0)
            rx_steady = !rx_steady;
         stall = idle_draw(rx_steady);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         book.check_pixels(rsp_pixels);
         @(negedge clock);
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WatchdogLimit) begin
         $display("FAIL mda_text_cell_renderer_core");
         $finish;
      end
   end

   initial begin
      req_valid      = 1'b0;
      req_op         = OP_CELL;
      req_char_code  = '0;
      req_attribute  = '0;
      req_glyph_bits = '0;
      req_is_cursor  = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = ADDR_MODE_CONTROL;
      csr_pwdata     = '0;
      book.mode_byte = MODE_OFF;
      book.frames    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // display off after reset: cells vanish, ticks still count
      send_request(random_cell());
      send_ticks(2);
      send_request(random_cell());
      send_request(random_cell());

      // intensity mode: colours, invisible, reverse, underline, ninth column, cursor
      set_mode(MODE_INTEN);
      send_cell(8'h41, 8'h07, 8'hA5, 1'b0);
      send_cell(8'hC0, 8'h0F, 8'h81, 1'b0);
      send_cell(8'hDF, 8'h07, 8'h01, 1'b0);
      send_cell(8'hE0, 8'h07, 8'h01, 1'b0);
      send_cell(8'h00, 8'h00, 8'hFF, 1'b0);
      send_cell(8'hFF, 8'h88, 8'hFF, 1'b0);
      send_cell(8'h20, ATTR_REV, 8'h3C, 1'b0);
      send_cell(8'hC5, ATTR_REV_HI, 8'h3D, 1'b0);
      send_cell(8'h20, ATTR_REV_BL, 8'h3C, 1'b0);
      send_cell(8'hD1, ATTR_REV_BL_HI, 8'h3D, 1'b0);
      send_cell(8'h5F, 8'h09, 8'h00, 1'b0);
      send_cell(8'h41, 8'h07, 8'h00, 1'b1);

      // unmapped addresses must leave the mode alone
      stop_requests();
      wait_drained();
      repeat (SettleCycles) @(negedge clock);
      for (int a = FirstUnmapped; a < AddrCount; a++)
         csr_write(CsrAddrW'(a), MODE_ALL_ONES);

      // blink mode: cursor phase, then attribute blink against the cursor cell
      set_mode(MODE_BLINK);
      send_cell(8'h20, ATTR_REV_BL, 8'h3C, 1'b0);
      send_cell(8'h20, ATTR_REV_BL_HI, 8'h3C, 1'b0);
      send_ticks(8);
      send_cell(8'h41, 8'h87, 8'hFF, 1'b0);
      send_cell(8'h41, 8'h07, 8'h00, 1'b1);
      send_ticks(8);
      send_cell(8'h41, 8'h87, 8'hFF, 1'b0);
      send_cell(8'hC3, 8'h8F, 8'hFF, 1'b1);

      // random phases over several mode settings
      run_phase(MODE_INTEN | (MODE_SPARE & ModeW'($urandom)), 55, 1'b0);
      run_phase(MODE_ALL_ONES, 12, 1'b0);
      run_phase(MODE_BLINK | (MODE_SPARE & ModeW'($urandom)), 60, 1'b1);
      run_phase(ModeW'($urandom), 40, 1'b0);
      run_phase(MODE_BLINK | MODE_SPARE, 60, 1'b0);
      run_phase(MODE_OFF, 12, 1'b0);
      run_phase(MODE_INTEN, 60, 1'b0);
      run_phase(MODE_BLINK, 60, 1'b0);
      run_phase(MODE_INTEN | MODE_SPARE, 50, 1'b0);

      stop_requests();
      wait_drained();
      repeat (EndCycles) @(negedge clock);
      book.close();
      if (book.mismatches == 0)
         $display("PASS mda_text_cell_renderer_core");
      else
         $display("FAIL mda_text_cell_renderer_core");
      $finish;
   end

endmodule
